FILE: sv/qru_pkg.sv
// Package for the quaternion rotation unit: value limits, microcode word type,
// operand bank and entry point codes, and the microcode ROM itself.
// No dependencies; imported by quaternion_rotation_unit.
package qru_pkg;

    localparam int VAL_W = 24;
    localparam int PROD_W = 2 * VAL_W;
    // Four truncated products, one of them doubled, fit in PROD_W + 3 bits.
    localparam int ACC_W = PROD_W + 4;
    localparam int MATRIX_DIM = 4;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7fffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

    // Operation codes on s_func.
    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_IDENT  = 3'd1;
    localparam logic [2:0] FN_MUL    = 3'd2;
    localparam logic [2:0] FN_CONJ   = 3'd3;
    localparam logic [2:0] FN_ROT    = 3'd4;
    localparam logic [2:0] FN_MATRIX = 3'd5;

    // Operand banks.
    localparam logic [2:0] BK_Q    = 3'd0;
    localparam logic [2:0] BK_B    = 3'd1;
    localparam logic [2:0] BK_R    = 3'd2;
    localparam logic [2:0] BK_T    = 3'd3;
    localparam logic [2:0] BK_ZERO = 3'd4;
    localparam logic [2:0] BK_ONE  = 3'd5;

    // Component indexes within a bank.
    localparam logic [1:0] IW = 2'd0;
    localparam logic [1:0] IX = 2'd1;
    localparam logic [1:0] IY = 2'd2;
    localparam logic [1:0] IZ = 2'd3;

    // Write-back destinations.
    localparam logic DST_R = 1'b0;
    localparam logic DST_T = 1'b1;

    localparam int PC_W = 7;
    localparam int PROG_LEN = 125;

    localparam logic [PC_W-1:0] EP_LOAD   = 7'd0;
    localparam logic [PC_W-1:0] EP_IDENT  = 7'd7;
    localparam logic [PC_W-1:0] EP_CONJ   = 7'd14;
    localparam logic [PC_W-1:0] EP_MUL    = 7'd21;
    localparam logic [PC_W-1:0] EP_ROT    = 7'd40;
    localparam logic [PC_W-1:0] EP_MATRIX = 7'd79;

    typedef struct packed {
        logic       act;      // step feeds a term into the multiply/accumulate path
        logic [2:0] a_bank;
        logic [1:0] a_idx;
        logic [2:0] b_bank;
        logic [1:0] b_idx;
        logic       mul;      // 1: truncated product, 0: pass operand a
        logic       first;    // term starts a new sum
        logic       neg;
        logic       dbl;
        logic       wr;       // saturated sum is written back after this term
        logic       dst_t;
        logic [1:0] dst_idx;
        logic       emit;     // copy R to the output register
        logic       commit;   // copy R to the stored quaternion
        logic       last;
        logic       done;     // program ends after this step
    } uword_t;

    typedef struct packed {
        logic       valid;
        logic       mul;
        logic       first;
        logic       neg;
        logic       dbl;
        logic       wr;
        logic       dst_t;
        logic [1:0] dst_idx;
    } term_ctl_t;

    typedef struct packed {
        logic       wr;
        logic       dst_t;
        logic [1:0] dst_idx;
    } wb_ctl_t;

    function automatic uword_t op_nop();
        uword_t u;
        u = '0;
        return u;
    endfunction

    function automatic uword_t op_mul(input logic [2:0] ab, input logic [1:0] ai,
                                      input logic [2:0] bb, input logic [1:0] bi,
                                      input logic fst, input logic ng, input logic db,
                                      input logic w, input logic dt, input logic [1:0] di);
        uword_t u;
        u = '0;
        u.act = 1'b1;
        u.a_bank = ab;
        u.a_idx = ai;
        u.b_bank = bb;
        u.b_idx = bi;
        u.mul = 1'b1;
        u.first = fst;
        u.neg = ng;
        u.dbl = db;
        u.wr = w;
        u.dst_t = dt;
        u.dst_idx = di;
        return u;
    endfunction

    function automatic uword_t op_pass(input logic [2:0] ab, input logic [1:0] ai,
                                       input logic ng, input logic dt, input logic [1:0] di);
        uword_t u;
        u = '0;
        u.act = 1'b1;
        u.a_bank = ab;
        u.a_idx = ai;
        u.first = 1'b1;
        u.neg = ng;
        u.wr = 1'b1;
        u.dst_t = dt;
        u.dst_idx = di;
        return u;
    endfunction

    function automatic uword_t op_emit(input logic cm, input logic lst, input logic dn);
        uword_t u;
        u = '0;
        u.emit = 1'b1;
        u.commit = cm;
        u.last = lst;
        u.done = dn;
        return u;
    endfunction

    function automatic uword_t op_end();
        uword_t u;
        u = '0;
        u.done = 1'b1;
        return u;
    endfunction

    // Microcode ROM. Two empty steps follow every group of writes so that the
    // written values have landed before the next step reads them.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t u;
        case (pc)
            // Load: R = B, then commit.
            7'd0:   u = op_pass(BK_B, IW, 1'b0, DST_R, IW);
            7'd1:   u = op_pass(BK_B, IX, 1'b0, DST_R, IX);
            7'd2:   u = op_pass(BK_B, IY, 1'b0, DST_R, IY);
            7'd3:   u = op_pass(BK_B, IZ, 1'b0, DST_R, IZ);
            7'd4:   u = op_nop();
            7'd5:   u = op_nop();
            7'd6:   u = op_emit(1'b1, 1'b1, 1'b1);
            // Identity.
            7'd7:   u = op_pass(BK_ONE, IW, 1'b0, DST_R, IW);
            7'd8:   u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IX);
            7'd9:   u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IY);
            7'd10:  u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IZ);
            7'd11:  u = op_nop();
            7'd12:  u = op_nop();
            7'd13:  u = op_emit(1'b1, 1'b1, 1'b1);
            // Conjugate.
            7'd14:  u = op_pass(BK_Q, IW, 1'b0, DST_R, IW);
            7'd15:  u = op_pass(BK_Q, IX, 1'b1, DST_R, IX);
            7'd16:  u = op_pass(BK_Q, IY, 1'b1, DST_R, IY);
            7'd17:  u = op_pass(BK_Q, IZ, 1'b1, DST_R, IZ);
            7'd18:  u = op_nop();
            7'd19:  u = op_nop();
            7'd20:  u = op_emit(1'b1, 1'b1, 1'b1);
            // Multiply: R = Q * B.
            7'd21:  u = op_mul(BK_Q, IW, BK_B, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd22:  u = op_mul(BK_Q, IX, BK_B, IX, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IW);
            7'd23:  u = op_mul(BK_Q, IY, BK_B, IY, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IW);
            7'd24:  u = op_mul(BK_Q, IZ, BK_B, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IW);
            7'd25:  u = op_mul(BK_Q, IW, BK_B, IX, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd26:  u = op_mul(BK_Q, IX, BK_B, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd27:  u = op_mul(BK_Q, IY, BK_B, IZ, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd28:  u = op_mul(BK_Q, IZ, BK_B, IY, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IX);
            7'd29:  u = op_mul(BK_Q, IW, BK_B, IY, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd30:  u = op_mul(BK_Q, IY, BK_B, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd31:  u = op_mul(BK_Q, IZ, BK_B, IX, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd32:  u = op_mul(BK_Q, IX, BK_B, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IY);
            7'd33:  u = op_mul(BK_Q, IW, BK_B, IZ, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd34:  u = op_mul(BK_Q, IZ, BK_B, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd35:  u = op_mul(BK_Q, IX, BK_B, IY, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd36:  u = op_mul(BK_Q, IY, BK_B, IX, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IZ);
            7'd37:  u = op_nop();
            7'd38:  u = op_nop();
            7'd39:  u = op_emit(1'b1, 1'b1, 1'b1);
            // Rotate: R = conj(Q), T = R * (0, v), R = T * Q stored as (x, y, z, w).
            7'd40:  u = op_pass(BK_Q, IW, 1'b0, DST_R, IW);
            7'd41:  u = op_pass(BK_Q, IX, 1'b1, DST_R, IX);
            7'd42:  u = op_pass(BK_Q, IY, 1'b1, DST_R, IY);
            7'd43:  u = op_pass(BK_Q, IZ, 1'b1, DST_R, IZ);
            7'd44:  u = op_nop();
            7'd45:  u = op_nop();
            // Terms with the zero scalar of the vector are exactly zero and skipped.
            7'd46:  u = op_mul(BK_R, IX, BK_B, IX, 1'b1, 1'b1, 1'b0, 1'b0, DST_T, IW);
            7'd47:  u = op_mul(BK_R, IY, BK_B, IY, 1'b0, 1'b1, 1'b0, 1'b0, DST_T, IW);
            7'd48:  u = op_mul(BK_R, IZ, BK_B, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_T, IW);
            7'd49:  u = op_mul(BK_R, IW, BK_B, IX, 1'b1, 1'b0, 1'b0, 1'b0, DST_T, IX);
            7'd50:  u = op_mul(BK_R, IY, BK_B, IZ, 1'b0, 1'b0, 1'b0, 1'b0, DST_T, IX);
            7'd51:  u = op_mul(BK_R, IZ, BK_B, IY, 1'b0, 1'b1, 1'b0, 1'b1, DST_T, IX);
            7'd52:  u = op_mul(BK_R, IW, BK_B, IY, 1'b1, 1'b0, 1'b0, 1'b0, DST_T, IY);
            7'd53:  u = op_mul(BK_R, IZ, BK_B, IX, 1'b0, 1'b0, 1'b0, 1'b0, DST_T, IY);
            7'd54:  u = op_mul(BK_R, IX, BK_B, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_T, IY);
            7'd55:  u = op_mul(BK_R, IW, BK_B, IZ, 1'b1, 1'b0, 1'b0, 1'b0, DST_T, IZ);
            7'd56:  u = op_mul(BK_R, IX, BK_B, IY, 1'b0, 1'b0, 1'b0, 1'b0, DST_T, IZ);
            7'd57:  u = op_mul(BK_R, IY, BK_B, IX, 1'b0, 1'b1, 1'b0, 1'b1, DST_T, IZ);
            7'd58:  u = op_nop();
            7'd59:  u = op_nop();
            7'd60:  u = op_mul(BK_T, IW, BK_Q, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd61:  u = op_mul(BK_T, IX, BK_Q, IX, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IZ);
            7'd62:  u = op_mul(BK_T, IY, BK_Q, IY, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IZ);
            7'd63:  u = op_mul(BK_T, IZ, BK_Q, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IZ);
            7'd64:  u = op_mul(BK_T, IW, BK_Q, IX, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd65:  u = op_mul(BK_T, IX, BK_Q, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd66:  u = op_mul(BK_T, IY, BK_Q, IZ, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd67:  u = op_mul(BK_T, IZ, BK_Q, IY, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IW);
            7'd68:  u = op_mul(BK_T, IW, BK_Q, IY, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd69:  u = op_mul(BK_T, IY, BK_Q, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd70:  u = op_mul(BK_T, IZ, BK_Q, IX, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd71:  u = op_mul(BK_T, IX, BK_Q, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IX);
            7'd72:  u = op_mul(BK_T, IW, BK_Q, IZ, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd73:  u = op_mul(BK_T, IZ, BK_Q, IW, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd74:  u = op_mul(BK_T, IX, BK_Q, IY, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd75:  u = op_mul(BK_T, IY, BK_Q, IX, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IY);
            7'd76:  u = op_nop();
            7'd77:  u = op_nop();
            7'd78:  u = op_emit(1'b0, 1'b1, 1'b1);
            // To matrix, row 0.
            7'd79:  u = op_mul(BK_Q, IW, BK_Q, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd80:  u = op_mul(BK_Q, IX, BK_Q, IX, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IW);
            7'd81:  u = op_mul(BK_Q, IY, BK_Q, IY, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IW);
            7'd82:  u = op_mul(BK_Q, IZ, BK_Q, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IW);
            7'd83:  u = op_mul(BK_Q, IX, BK_Q, IY, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IX);
            7'd84:  u = op_mul(BK_Q, IW, BK_Q, IZ, 1'b0, 1'b1, 1'b1, 1'b1, DST_R, IX);
            7'd85:  u = op_mul(BK_Q, IZ, BK_Q, IX, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IY);
            7'd86:  u = op_mul(BK_Q, IW, BK_Q, IY, 1'b0, 1'b0, 1'b1, 1'b1, DST_R, IY);
            7'd87:  u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IZ);
            7'd88:  u = op_nop();
            7'd89:  u = op_nop();
            7'd90:  u = op_emit(1'b0, 1'b0, 1'b0);
            // Row 1.
            7'd91:  u = op_mul(BK_Q, IX, BK_Q, IY, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IW);
            7'd92:  u = op_mul(BK_Q, IW, BK_Q, IZ, 1'b0, 1'b0, 1'b1, 1'b1, DST_R, IW);
            7'd93:  u = op_mul(BK_Q, IW, BK_Q, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd94:  u = op_mul(BK_Q, IX, BK_Q, IX, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IX);
            7'd95:  u = op_mul(BK_Q, IY, BK_Q, IY, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IX);
            7'd96:  u = op_mul(BK_Q, IZ, BK_Q, IZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_R, IX);
            7'd97:  u = op_mul(BK_Q, IY, BK_Q, IZ, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IY);
            7'd98:  u = op_mul(BK_Q, IW, BK_Q, IX, 1'b0, 1'b1, 1'b1, 1'b1, DST_R, IY);
            7'd99:  u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IZ);
            7'd100: u = op_nop();
            7'd101: u = op_nop();
            7'd102: u = op_emit(1'b0, 1'b0, 1'b0);
            // Row 2.
            7'd103: u = op_mul(BK_Q, IZ, BK_Q, IX, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IW);
            7'd104: u = op_mul(BK_Q, IW, BK_Q, IY, 1'b0, 1'b1, 1'b1, 1'b1, DST_R, IW);
            7'd105: u = op_mul(BK_Q, IY, BK_Q, IZ, 1'b1, 1'b0, 1'b1, 1'b0, DST_R, IX);
            7'd106: u = op_mul(BK_Q, IW, BK_Q, IX, 1'b0, 1'b0, 1'b1, 1'b1, DST_R, IX);
            7'd107: u = op_mul(BK_Q, IW, BK_Q, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IY);
            7'd108: u = op_mul(BK_Q, IX, BK_Q, IX, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IY);
            7'd109: u = op_mul(BK_Q, IY, BK_Q, IY, 1'b0, 1'b1, 1'b0, 1'b0, DST_R, IY);
            7'd110: u = op_mul(BK_Q, IZ, BK_Q, IZ, 1'b0, 1'b0, 1'b0, 1'b1, DST_R, IY);
            7'd111: u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IZ);
            7'd112: u = op_nop();
            7'd113: u = op_nop();
            7'd114: u = op_emit(1'b0, 1'b0, 1'b0);
            // Row 3.
            7'd115: u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IW);
            7'd116: u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IX);
            7'd117: u = op_pass(BK_ZERO, IW, 1'b0, DST_R, IY);
            7'd118: u = op_mul(BK_Q, IW, BK_Q, IW, 1'b1, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd119: u = op_mul(BK_Q, IX, BK_Q, IX, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd120: u = op_mul(BK_Q, IY, BK_Q, IY, 1'b0, 1'b0, 1'b0, 1'b0, DST_R, IZ);
            7'd121: u = op_mul(BK_Q, IZ, BK_Q, IZ, 1'b0, 1'b0, 1'b0, 1'b1, DST_R, IZ);
            7'd122: u = op_nop();
            7'd123: u = op_nop();
            7'd124: u = op_emit(1'b0, 1'b1, 1'b1);
            default: u = op_end();
        endcase
        return u;
    endfunction

    function automatic logic [PC_W-1:0] entry_point(input logic [2:0] fn);
        logic [PC_W-1:0] ep;
        case (fn)
            FN_LOAD:   ep = EP_LOAD;
            FN_IDENT:  ep = EP_IDENT;
            FN_MUL:    ep = EP_MUL;
            FN_CONJ:   ep = EP_CONJ;
            FN_ROT:    ep = EP_ROT;
            FN_MATRIX: ep = EP_MATRIX;
            default:   ep = EP_LOAD;
        endcase
        return ep;
    endfunction

endpackage

FILE: sv/quaternion_rotation_unit.sv
// Quaternion rotation unit: microcode sequencer, operand register banks,
// shared multiplier and saturating accumulator. Depends on qru_pkg.
//
// Usage: one item on the s_ channel carries an operation code (s_func) and a
// quaternion or vector operand. Load, identity, multiply and conjugate replace
// the stored orientation and return the new value in one transfer. Rotate
// returns conj(q) * v * q as (x, y, z, w) in one transfer. To-matrix returns
// the four rows of the rotation matrix in four transfers. m_last marks the
// final transfer of an operation. Codes 6 and 7 are taken and ignored.
// Timing: the sequencer runs one microcode step per cycle while no emit step
// waits for the output register, and every product goes through the one
// 24x24 multiplier. An operation's program holds 7 steps (load, identity,
// conjugate), 19 (multiply), 39 (rotate, twelve plus sixteen products) or 46
// (matrix) up to its last transfer; s_ready is low while it runs and returns
// high in the same cycle as the final result appears in the output register.
// A stalled receiver holds the sequencer on its emit step; the output register
// frees the block once the last transfer is loaded. Reset clears the sequencer
// and output valid and sets the stored quaternion to identity.
module quaternion_rotation_unit
    import qru_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_func,
    input  logic signed [VAL_W-1:0] s_in_w,
    input  logic signed [VAL_W-1:0] s_in_x,
    input  logic signed [VAL_W-1:0] s_in_y,
    input  logic signed [VAL_W-1:0] s_in_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_col0,
    output logic signed [VAL_W-1:0] m_col1,
    output logic signed [VAL_W-1:0] m_col2,
    output logic signed [VAL_W-1:0] m_col3,
    output logic                    m_last
);

    // 1.0 saturates once FRAC_BITS leaves no integer bit for it.
    localparam logic signed [VAL_W-1:0] ONE_VAL =
        (FRAC_BITS >= VAL_W - 1) ? VAL_MAX : VAL_W'(2 ** FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(VAL_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(VAL_MIN);

    // Sequencer state.
    logic                  busy_reg;
    logic [PC_W-1:0]       pc_reg;
    uword_t                uw;
    logic                  s_accept;
    logic                  out_free;
    logic                  issue;

    // Operand banks: stored quaternion, input operand, result and temporary.
    logic signed [VAL_W-1:0] q_reg [4];
    logic signed [VAL_W-1:0] b_reg [4];
    logic signed [VAL_W-1:0] r_reg [4];
    logic signed [VAL_W-1:0] t_reg [4];

    // Datapath pipeline.
    logic signed [VAL_W-1:0]  opa;
    logic signed [VAL_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  pass_reg;
    term_ctl_t                c1_reg;
    term_ctl_t                c1_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term_raw;
    logic signed [ACC_W-1:0]  term_sh;
    logic signed [ACC_W-1:0]  term;
    wb_ctl_t                  c2_reg;
    logic signed [VAL_W-1:0]  wb_val;

    // Output register.
    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic signed [VAL_W-1:0] m_col_reg [4];

    assign uw       = ucode(pc_reg);
    assign s_ready  = !busy_reg;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // An emit step waits until the output register can take the result.
    assign issue    = busy_reg && (!uw.emit || out_free);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (uw.a_bank)
            BK_Q:    opa = q_reg[uw.a_idx];
            BK_B:    opa = b_reg[uw.a_idx];
            BK_R:    opa = r_reg[uw.a_idx];
            BK_T:    opa = t_reg[uw.a_idx];
            BK_ONE:  opa = ONE_VAL;
            default: opa = '0;
        endcase
        case (uw.b_bank)
            BK_Q:    opb = q_reg[uw.b_idx];
            BK_B:    opb = b_reg[uw.b_idx];
            BK_R:    opb = r_reg[uw.b_idx];
            BK_T:    opb = t_reg[uw.b_idx];
            BK_ONE:  opb = ONE_VAL;
            default: opb = '0;
        endcase
    end

    always_comb begin
        c1_next         = '0;
        c1_next.valid   = issue && uw.act;
        c1_next.mul     = uw.mul;
        c1_next.first   = uw.first;
        c1_next.neg     = uw.neg;
        c1_next.dbl     = uw.dbl;
        c1_next.wr      = uw.wr;
        c1_next.dst_t   = uw.dst_t;
        c1_next.dst_idx = uw.dst_idx;
    end

    // Products are floored by an arithmetic shift; a passed operand enters as is.
    assign term_raw = c1_reg.mul ? ACC_W'(prod_reg >>> FRAC_BITS) : ACC_W'(pass_reg);
    assign term_sh  = c1_reg.dbl ? (term_raw <<< 1) : term_raw;
    assign term     = c1_reg.neg ? -term_sh : term_sh;
    assign acc_next = c1_reg.first ? term : acc_reg + term;

    always_comb begin
        if (acc_reg > ACC_MAX) begin
            wb_val = VAL_MAX;
        end else if (acc_reg < ACC_MIN) begin
            wb_val = VAL_MIN;
        end else begin
            wb_val = acc_reg[VAL_W-1:0];
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end else if (s_accept) begin
            busy_reg <= s_func inside {[FN_LOAD:FN_MATRIX]};
            pc_reg   <= entry_point(s_func);
        end else if (issue) begin
            if (uw.done) begin
                busy_reg <= 1'b0;
            end else begin
                pc_reg <= pc_reg + 1'b1;
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
        end else begin
            c1_reg         <= c1_next;
            c2_reg.wr      <= c1_reg.valid && c1_reg.wr;
            c2_reg.dst_t   <= c1_reg.dst_t;
            c2_reg.dst_idx <= c1_reg.dst_idx;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(opa) * PROD_W'(opb);
        pass_reg <= opa;
        if (c1_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (s_accept) begin
            b_reg[0] <= s_in_w;
            b_reg[1] <= s_in_x;
            b_reg[2] <= s_in_y;
            b_reg[3] <= s_in_z;
        end
        if (c2_reg.wr) begin
            if (c2_reg.dst_t) begin
                t_reg[c2_reg.dst_idx] <= wb_val;
            end else begin
                r_reg[c2_reg.dst_idx] <= wb_val;
            end
        end
        if (issue && uw.emit) begin
            m_col_reg <= r_reg;
            m_last_reg <= uw.last;
        end
    end

    // Stored orientation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= ONE_VAL;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end else if (issue && uw.commit) begin
            q_reg <= r_reg;
        end
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (issue && uw.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_last  = m_last_reg;
    assign m_col0  = m_col_reg[0];
    assign m_col1  = m_col_reg[1];
    assign m_col2  = m_col_reg[2];
    assign m_col3  = m_col_reg[3];

    // The result bank must be settled when it is copied out.
    a_emit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && uw.emit) |-> (!c1_reg.valid && !c2_reg.wr))
        else $error("emit step reached with write-back still in flight");

    // A final transfer ends the program.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && uw.emit && uw.last) |=> !busy_reg)
        else $error("sequencer still busy after final result");

    // The block only reports ready with an empty datapath.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!c1_reg.valid && !c2_reg.wr))
        else $error("ready while terms are still in the datapath");

    // The step counter stays inside the program while it runs.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg < PC_W'(PROG_LEN)))
        else $error("step counter left the microcode program");

endmodule

FILE: tb/tb_quaternion_rotation_unit.sv
// Self-checking testbench for quaternion_rotation_unit: a scoreboard class that
// predicts every result transfer, plus tasks that drive the operation channel.
// Depends on qru_pkg and the quaternion_rotation_unit RTL.
`timescale 1ns / 1ps

typedef logic signed [qru_pkg::VAL_W-1:0] val_t;

typedef struct packed {
    val_t w;
    val_t x;
    val_t y;
    val_t z;
} quat_t;

typedef struct packed {
    val_t c0;
    val_t c1;
    val_t c2;
    val_t c3;
    logic last;
} row_t;

// Tracks the stored orientation, and queues the rows that each accepted
// operation must produce.
class quat_scoreboard;
    localparam int FRAC = 16;

    quat_t orient;
    row_t  expected_rows[$];
    int    fails;

    function new();
        orient.w = val_t'(1 << FRAC);
        orient.x = '0;
        orient.y = '0;
        orient.z = '0;
        fails = 0;
    endfunction

    function val_t sat(longint v);
        if (v > longint'(qru_pkg::VAL_MAX)) return qru_pkg::VAL_MAX;
        if (v < longint'(qru_pkg::VAL_MIN)) return qru_pkg::VAL_MIN;
        return val_t'(v);
    endfunction

    // Truncating fixed-point product: the arithmetic shift rounds toward minus infinity.
    function longint fmul(val_t a, val_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC;
    endfunction

    function quat_t hamilton(quat_t a, quat_t b);
        quat_t r;
        r.w = sat(fmul(a.w, b.w) - fmul(a.x, b.x) - fmul(a.y, b.y) - fmul(a.z, b.z));
        r.x = sat(fmul(a.w, b.x) + fmul(b.w, a.x) + fmul(a.y, b.z) - fmul(a.z, b.y));
        r.y = sat(fmul(a.w, b.y) + fmul(b.w, a.y) + fmul(a.z, b.x) - fmul(a.x, b.z));
        r.z = sat(fmul(a.w, b.z) + fmul(b.w, a.z) + fmul(a.x, b.y) - fmul(a.y, b.x));
        return r;
    endfunction

    function quat_t conjugate(quat_t a);
        quat_t r;
        r.w = a.w;
        r.x = sat(-longint'(a.x));
        r.y = sat(-longint'(a.y));
        r.z = sat(-longint'(a.z));
        return r;
    endfunction

    function void push_row(longint c0, longint c1, longint c2, longint c3, logic lst);
        row_t row;
        row.c0 = sat(c0);
        row.c1 = sat(c1);
        row.c2 = sat(c2);
        row.c3 = sat(c3);
        row.last = lst;
        expected_rows.push_back(row);
    endfunction

    function void note_operation(logic [2:0] fn, quat_t opnd);
        quat_t  vec;
        quat_t  tmp;
        quat_t  rot;
        longint ww, xx, yy, zz, wx, wy, wz, xy, yz, zx;
        case (fn)
            qru_pkg::FN_LOAD: begin
                orient = opnd;
                push_row(orient.w, orient.x, orient.y, orient.z, 1'b1);
            end
            qru_pkg::FN_IDENT: begin
                orient.w = val_t'(1 << FRAC);
                orient.x = '0;
                orient.y = '0;
                orient.z = '0;
                push_row(orient.w, orient.x, orient.y, orient.z, 1'b1);
            end
            qru_pkg::FN_MUL: begin
                orient = hamilton(orient, opnd);
                push_row(orient.w, orient.x, orient.y, orient.z, 1'b1);
            end
            qru_pkg::FN_CONJ: begin
                orient = conjugate(orient);
                push_row(orient.w, orient.x, orient.y, orient.z, 1'b1);
            end
            qru_pkg::FN_ROT: begin
                vec = opnd;
                vec.w = '0;
                tmp = hamilton(conjugate(orient), vec);
                rot = hamilton(tmp, orient);
                push_row(rot.x, rot.y, rot.z, rot.w, 1'b1);
            end
            qru_pkg::FN_MATRIX: begin
                ww = fmul(orient.w, orient.w);
                xx = fmul(orient.x, orient.x);
                yy = fmul(orient.y, orient.y);
                zz = fmul(orient.z, orient.z);
                wx = fmul(orient.w, orient.x);
                wy = fmul(orient.w, orient.y);
                wz = fmul(orient.w, orient.z);
                xy = fmul(orient.x, orient.y);
                yz = fmul(orient.y, orient.z);
                zx = fmul(orient.z, orient.x);
                push_row(ww + xx - yy - zz, 2 * (xy - wz), 2 * (zx + wy), 0, 1'b0);
                push_row(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx), 0, 1'b0);
                push_row(2 * (zx - wy), 2 * (yz + wx), ww - xx - yy + zz, 0, 1'b0);
                push_row(0, 0, 0, ww + xx + yy + zz, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function void check_row(row_t got);
        row_t want;
        if (expected_rows.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected result: %0d %0d %0d %0d last %0b",
                         got.c0, got.c1, got.c2, got.c3, got.last);
            return;
        end
        want = expected_rows.pop_front();
        if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
            got.c3 !== want.c3 || got.last !== want.last) begin
            fails++;
            if (fails <= 10)
                $display("mismatch: expected %0d %0d %0d %0d last %0b, got %0d %0d %0d %0d last %0b",
                         want.c0, want.c1, want.c2, want.c3, want.last,
                         got.c0, got.c1, got.c2, got.c3, got.last);
        end
    endfunction
endclass

module tb_quaternion_rotation_unit;
    import qru_pkg::*;

    // The two codes past the last operation; the block takes them and does nothing.
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam int   FRAC_BITS    = 16;
    localparam int   RANDOM_ITEMS = 100;
    localparam val_t ONE          = 24'sd65536;
    localparam val_t HALF         = 24'sd32768;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_func;
    val_t       s_in_w;
    val_t       s_in_x;
    val_t       s_in_y;
    val_t       s_in_z;
    logic       m_valid;
    logic       m_ready;
    val_t       m_col0;
    val_t       m_col1;
    val_t       m_col2;
    val_t       m_col3;
    logic       m_last;

    quat_scoreboard board;

    quaternion_rotation_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .s_in_w (s_in_w),
        .s_in_x (s_in_x),
        .s_in_y (s_in_y),
        .s_in_z (s_in_z),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_col0 (m_col0),
        .m_col1 (m_col1),
        .m_col2 (m_col2),
        .m_col3 (m_col3),
        .m_last (m_last)
    );

    always #10 aclk = ~aclk;

    // Operand values: the extremes, values between -1.0 and 1.0 where a quaternion
    // normally lives, and fully random words that toggle every bit.
    function automatic val_t rand_val();
        int unsigned pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return ONE;
            4: return -ONE;
            5, 6, 7: return val_t'($signed($urandom_range(0, 131072)) - 65536);
            default: return val_t'($urandom);
        endcase
    endfunction

    // Presents one operation and holds it until the transfer happens. It is
    // called right after a rising edge. Valid is left high so that a following
    // item can be presented in the same time step without a second assignment.
    task automatic send_item(input logic [2:0] fn, input val_t w, input val_t x,
                             input val_t y, input val_t z);
        quat_t opnd;
        opnd.w = w;
        opnd.x = x;
        opnd.y = y;
        opnd.z = z;
        s_valid <= 1'b1;
        s_func  <= fn;
        s_in_w  <= w;
        s_in_x  <= x;
        s_in_y  <= y;
        s_in_z  <= z;
        // The values seen right after the edge are the ones the block sampled.
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_operation(fn, opnd);
    endtask

    // Drops valid for a number of cycles; the payload carries junk meanwhile.
    task automatic idle_gap(input int cycles);
        s_valid <= 1'b0;
        s_func  <= 3'($urandom);
        s_in_w  <= val_t'($urandom);
        s_in_x  <= val_t'($urandom);
        s_in_y  <= val_t'($urandom);
        s_in_z  <= val_t'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    // One random operation, weighted toward the arithmetic ones. Returns
    // whether the block does anything with it.
    task automatic send_random_item(output bit counted);
        int unsigned pick;
        logic [2:0]  fn;
        pick = $urandom_range(0, 99);
        if (pick < 14)      fn = FN_LOAD;
        else if (pick < 19) fn = FN_IDENT;
        else if (pick < 39) fn = FN_MUL;
        else if (pick < 49) fn = FN_CONJ;
        else if (pick < 74) fn = FN_ROT;
        else if (pick < 92) fn = FN_MATRIX;
        else if (pick < 96) fn = FN_SPARE6;
        else                fn = FN_SPARE7;
        counted = (fn != FN_SPARE6) && (fn != FN_SPARE7);
        send_item(fn, rand_val(), rand_val(), rand_val(), rand_val());
    endtask

    // Receiver side: checks every result transfer against the scoreboard and
    // drives m_ready from a pattern that is redrawn at random, on a period kept by rx_cycle,
    // among always ready, coin flips, a fixed one-in-five duty and long stalls.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;

    always @(posedge aclk) begin : rx_side
        row_t got;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            got.c0 = m_col0;
            got.c1 = m_col1;
            got.c2 = m_col2;
            got.c3 = m_col3;
            got.last = m_last;
            board.check_row(got);
        end
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (rx_cycle % 5 == 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Stimulus and the end of the run.
    initial begin : stimulus
        int  useful;
        int  burst;
        int  gap;
        bit  counted;
        board   = new();
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func  = FN_LOAD;
        s_in_w  = '0;
        s_in_x  = '0;
        s_in_y  = '0;
        s_in_z  = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        @(posedge aclk);

        // Directed part. The matrix and the rotation of the reset orientation
        // come first, then saturating extremes in every operation, the
        // saturating negation of the most negative value, and the spare codes.
        send_item(FN_MATRIX, '0, '0, '0, '0);
        send_item(FN_ROT, VAL_MIN, ONE, -(ONE + ONE), VAL_MAX);
        send_item(FN_LOAD, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_item(FN_MATRIX, '0, '0, '0, '0);
        send_item(FN_MUL, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_item(FN_ROT, '0, VAL_MAX, VAL_MIN, VAL_MAX);
        send_item(FN_LOAD, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        send_item(FN_CONJ, '0, '0, '0, '0);
        send_item(FN_CONJ, '0, '0, '0, '0);
        send_item(FN_ROT, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN);
        send_item(FN_MATRIX, '0, '0, '0, '0);
        send_item(FN_MUL, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        idle_gap(5);
        send_item(FN_IDENT, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
        send_item(FN_SPARE6, ONE, ONE, ONE, ONE);
        send_item(FN_SPARE7, VAL_MIN, VAL_MAX, '0, ONE);
        send_item(FN_LOAD, HALF, HALF, HALF, HALF);
        send_item(FN_ROT, '0, ONE, '0, '0);
        send_item(FN_MATRIX, '0, '0, '0, '0);
        send_item(FN_MUL, '0, ONE, '0, '0);
        send_item(FN_CONJ, '0, '0, '0, '0);
        send_item(FN_LOAD, VAL_MAX, VAL_MIN, -24'sd1, 24'sd1);
        send_item(FN_MUL, VAL_MIN, VAL_MAX, '0, -24'sd1);
        send_item(FN_MATRIX, '0, '0, '0, '0);
        send_item(FN_LOAD, val_t'($urandom), val_t'($urandom), val_t'($urandom),
                  val_t'($urandom));
        idle_gap($urandom_range(1, 10));

        // Random part: bursts of random length with random gaps, and every
        // third burst or so runs straight into the next one.
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 6);
            for (int i = 0; i < burst; i++) begin
                send_random_item(counted);
                if (counted)
                    useful++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
                idle_gap(gap);
        end
        s_valid <= 1'b0;

        // Drain the outstanding rows, then watch a while for stray transfers.
        while (board.expected_rows.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (board.fails == 0 && board.expected_rows.size() == 0) begin
            $display("tb_quaternion_rotation_unit OK");
        end else begin
            $display("tb_quaternion_rotation_unit NOT OK");
        end
        $finish;
    end

    // A correct run takes well under a millisecond; this bound only catches a hang.
    initial begin : watchdog
        #5_000_000;
        $display("tb_quaternion_rotation_unit NOT OK");
        $finish;
    end

endmodule
